// ----- rtl/oful_pkg.sv -----
package oful_pkg;

    localparam logic [15:0] HDR_CODE   = 16'hCADE;
    localparam logic [15:0] HDR_DATA   = 16'hDADA;
    localparam logic [15:0] HDR_SYMBOL = 16'hC3B7;
    localparam logic [15:0] HDR_NAME   = 16'hF17E;
    localparam logic [15:0] HDR_LINE   = 16'h715E;

    localparam logic [15:0] LINE_SKIP_BYTES = 16'd6;

    localparam logic [1:0] KIND_EMPTY = 2'd0;
    localparam logic [1:0] KIND_CODE  = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [15:0] write_address;
        logic [15:0] write_data;
        logic [1:0]  write_kind;
    } result_t;

endpackage

// ----- rtl/oful_parser.sv -----
module oful_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        in_byte,
    output oful_pkg::result_t result
);

    typedef enum logic [3:0] {
        PH_SEEK  = 4'd0,
        PH_ADDR  = 4'd1,
        PH_COUNT = 4'd2,
        PH_WORDS = 4'd3,
        PH_SKIP  = 4'd4
    } phase_t;

    typedef enum logic [2:0] {
        SEC_NONE   = 3'd0,
        SEC_CODE   = 3'd1,
        SEC_DATA   = 3'd2,
        SEC_SYMBOL = 3'd3,
        SEC_NAME   = 3'd4,
        SEC_LINE   = 3'd5
    } section_t;

    phase_t      phase_reg, phase_next;
    section_t    section_reg, section_next;
    logic [15:0] header_window_reg, header_window_next;
    logic [7:0]  high_byte_reg, high_byte_next;
    logic        half_reg, half_next;
    logic [15:0] address_counter_reg, address_counter_next;
    logic [15:0] items_remaining_reg, items_remaining_next;

    logic [15:0] pair;
    logic [15:0] window;
    logic [15:0] items_dec;
    section_t    found;

    assign pair      = {high_byte_reg, in_byte};
    assign window    = {header_window_reg[7:0], in_byte};
    assign items_dec = (items_remaining_reg != 16'd0) ? items_remaining_reg - 16'd1
                                                      : items_remaining_reg;

    always_comb
    begin
        priority if (window == oful_pkg::HDR_CODE)   found = SEC_CODE;
        else if (window == oful_pkg::HDR_DATA)       found = SEC_DATA;
        else if (window == oful_pkg::HDR_SYMBOL)     found = SEC_SYMBOL;
        else if (window == oful_pkg::HDR_NAME)       found = SEC_NAME;
        else if (window == oful_pkg::HDR_LINE)       found = SEC_LINE;
        else                                         found = SEC_NONE;
    end

    always_comb
    begin
        phase_next           = phase_reg;
        section_next         = section_reg;
        header_window_next   = header_window_reg;
        high_byte_next       = high_byte_reg;
        half_next            = half_reg;
        address_counter_next = address_counter_reg;
        items_remaining_next = items_remaining_reg;
        result               = '0;

        unique case (phase_reg)
            PH_SEEK:
            begin
                header_window_next = window;
                if (found != SEC_NONE)
                begin
                    section_next       = found;
                    header_window_next = 16'd0;
                    half_next          = 1'b0;
                    if (found == SEC_LINE)
                    begin
                        items_remaining_next = oful_pkg::LINE_SKIP_BYTES;
                        phase_next           = PH_SKIP;
                    end
                    else if (found == SEC_NAME)
                    begin
                        phase_next = PH_COUNT;
                    end
                    else
                    begin
                        phase_next = PH_ADDR;
                    end
                end
            end
            PH_ADDR:
            begin
                if (!half_reg)
                begin
                    high_byte_next = in_byte;
                    half_next      = 1'b1;
                end
                else
                begin
                    address_counter_next = pair;
                    half_next            = 1'b0;
                    phase_next           = PH_COUNT;
                end
            end
            PH_COUNT:
            begin
                if (!half_reg)
                begin
                    high_byte_next = in_byte;
                    half_next      = 1'b1;
                end
                else
                begin
                    items_remaining_next = pair;
                    half_next            = 1'b0;
                    if (pair == 16'd0)
                        phase_next = PH_SEEK;
                    else if (section_reg == SEC_CODE || section_reg == SEC_DATA)
                        phase_next = PH_WORDS;
                    else
                        phase_next = PH_SKIP;
                end
            end
            PH_WORDS:
            begin
                if (!half_reg)
                begin
                    high_byte_next = in_byte;
                    half_next      = 1'b1;
                end
                else
                begin
                    half_next            = 1'b0;
                    result.valid         = 1'b1;
                    result.write_address = address_counter_reg;
                    result.write_data    = pair;
                    if (pair == 16'd0)
                        result.write_kind = oful_pkg::KIND_EMPTY;
                    else if (section_reg == SEC_CODE)
                        result.write_kind = oful_pkg::KIND_CODE;
                    else
                        result.write_kind = oful_pkg::KIND_DATA;
                    address_counter_next = address_counter_reg + 16'd1;
                    items_remaining_next = items_dec;
                    if (items_dec == 16'd0)
                        phase_next = PH_SEEK;
                end
            end
            PH_SKIP:
            begin
                items_remaining_next = items_dec;
                if (items_dec == 16'd0)
                    phase_next = PH_SEEK;
            end
            default:
            begin
                phase_next = PH_SEEK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_SEEK;
            section_reg         <= SEC_NONE;
            header_window_reg   <= 16'd0;
            high_byte_reg       <= 8'd0;
            half_reg            <= 1'b0;
            address_counter_reg <= 16'd0;
            items_remaining_reg <= 16'd0;
        end
        else if (step)
        begin
            phase_reg           <= phase_next;
            section_reg         <= section_next;
            header_window_reg   <= header_window_next;
            high_byte_reg       <= high_byte_next;
            half_reg            <= half_next;
            address_counter_reg <= address_counter_next;
            items_remaining_reg <= items_remaining_next;
        end
    end

    a_result_only_in_words: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (phase_reg == PH_WORDS && half_reg))
        else $error("write produced outside a word pair");

    a_header_clears_window: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_SEEK && found != SEC_NONE)
        |=> (header_window_reg == 16'd0 && !half_reg))
        else $error("window or pair flag not cleared on header");

    a_address_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.valid)
        |=> address_counter_reg == 16'($past(address_counter_reg) + 16'd1))
        else $error("address did not step after a word");

    a_skip_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_SKIP && items_remaining_reg == 16'd1)
        |=> phase_reg == PH_SEEK)
        else $error("skip did not return to seeking");

endmodule

// ----- rtl/object_file_section_loader.sv -----
// Object file section loader: takes one byte of an object file per beat on the
// slave side and returns one memory write per big-endian word of each code or
// data section on the master side; symbol, name and line sections are consumed
// with no output. It takes one byte every cycle when the master side is not
// stalled. A write is presented on the master side once the byte that completes
// its word has sat in the input register and the parser logic has loaded the
// output register from it. While a write waits on the master side the parser
// holds, and the slave side only fills an empty input register.
module object_file_section_loader
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // write_address, write_data
    output logic [1:0]  m_tuser    // write_kind
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    logic [15:0]       out_address_reg;
    logic [15:0]       out_data_reg;
    logic [1:0]        out_kind_reg;
    logic              advance;
    logic              step;
    oful_pkg::result_t result;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    oful_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .in_byte (in_byte_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= step && result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
        if (step && result.valid)
        begin
            out_address_reg <= result.write_address;
            out_data_reg    <= result.write_data;
            out_kind_reg    <= result.write_kind;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg, out_address_reg};
    assign m_tuser  = out_kind_reg;

endmodule

// ----- test/tb_object_file_section_loader.sv -----
`timescale 1ns / 1ps

module tb_object_file_section_loader;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_BYTES = 1400;
    localparam int PAUSE_EVERY = 350;
    localparam int MAX_PRINTS = 50;

    typedef enum logic [3:0] {
        PH_SEEK,
        PH_ADDR,
        PH_COUNT,
        PH_WORDS,
        PH_SKIP
    } parse_phase_t;

    typedef enum logic [2:0] {
        SEC_NONE,
        SEC_CODE,
        SEC_DATA,
        SEC_SYMBOL,
        SEC_NAME,
        SEC_LINE
    } section_t;

    typedef struct packed {
        logic [15:0] addr;
        logic [15:0] data;
        logic [1:0]  kind;
    } mem_write_t;

    typedef struct packed {
        logic [7:0] data;
        logic       hold;
    } stream_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    object_file_section_loader u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // in_byte
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // write_address, write_data
        .m_tuser  (m_tuser)    // write_kind
    );

    // loader state as predicted
    parse_phase_t phase = PH_SEEK;
    section_t     cur_section = SEC_NONE;
    logic [15:0]  hdr_window = '0;
    logic [7:0]   hi_byte = '0;
    logic         hi_valid = 1'b0;
    logic [15:0]  next_addr = '0;
    logic [15:0]  left_count = '0;

    mem_write_t   pending_writes[$];
    stream_byte_t byte_stream[$];
    stream_byte_t head_byte;

    int  errors = 0;
    int  cycles = 0;
    int  bytes_in = 0;
    int  writes_out = 0;
    int  total_pushed = 0;
    int  quiet = 0;
    int  src_gap = 0;
    int  src_burst = 0;
    int  snk_gap = 0;
    int  snk_burst = 0;
    int  sections_seen[6];
    int  empty_writes = 0;
    bit  pause_next = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic parse_byte(input logic [7:0] b);
        logic [15:0] w;
        section_t    found;
        begin
            case (phase)
                PH_SEEK:
                begin
                    w = {hdr_window[7:0], b};
                    hdr_window = w;
                    found = SEC_NONE;
                    if (w == oful_pkg::HDR_CODE)
                        found = SEC_CODE;
                    else if (w == oful_pkg::HDR_DATA)
                        found = SEC_DATA;
                    else if (w == oful_pkg::HDR_SYMBOL)
                        found = SEC_SYMBOL;
                    else if (w == oful_pkg::HDR_NAME)
                        found = SEC_NAME;
                    else if (w == oful_pkg::HDR_LINE)
                        found = SEC_LINE;
                    if (found != SEC_NONE)
                    begin
                        cur_section = found;
                        sections_seen[int'(found)]++;
                        hdr_window = '0;
                        hi_valid = 1'b0;
                        if (found == SEC_LINE)
                        begin
                            left_count = oful_pkg::LINE_SKIP_BYTES;
                            phase = PH_SKIP;
                        end
                        else if (found == SEC_NAME)
                            phase = PH_COUNT;
                        else
                            phase = PH_ADDR;
                    end
                end
                PH_ADDR:
                begin
                    if (!hi_valid)
                    begin
                        hi_byte = b;
                        hi_valid = 1'b1;
                    end
                    else
                    begin
                        next_addr = {hi_byte, b};
                        hi_valid = 1'b0;
                        phase = PH_COUNT;
                    end
                end
                PH_COUNT:
                begin
                    if (!hi_valid)
                    begin
                        hi_byte = b;
                        hi_valid = 1'b1;
                    end
                    else
                    begin
                        left_count = {hi_byte, b};
                        hi_valid = 1'b0;
                        if (left_count == 16'd0)
                            phase = PH_SEEK;
                        else if (cur_section == SEC_CODE || cur_section == SEC_DATA)
                            phase = PH_WORDS;
                        else
                            phase = PH_SKIP;
                    end
                end
                PH_WORDS:
                begin
                    if (!hi_valid)
                    begin
                        hi_byte = b;
                        hi_valid = 1'b1;
                    end
                    else
                    begin
                        w = {hi_byte, b};
                        hi_valid = 1'b0;
                        pending_writes.push_back('{next_addr, w,
                            (w == 16'd0) ? oful_pkg::KIND_EMPTY :
                            (cur_section == SEC_CODE ? oful_pkg::KIND_CODE
                                                     : oful_pkg::KIND_DATA)});
                        next_addr = next_addr + 16'd1;
                        if (left_count > 16'd0)
                            left_count = left_count - 16'd1;
                        if (left_count == 16'd0)
                            phase = PH_SEEK;
                    end
                end
                PH_SKIP:
                begin
                    if (left_count > 16'd0)
                        left_count = left_count - 16'd1;
                    if (left_count == 16'd0)
                        phase = PH_SEEK;
                end
                default:
                    phase = PH_SEEK;
            endcase
        end
    endtask

    function automatic int pick_gap(inout int burst);
        int r;
        begin
            if (burst > 0)
            begin
                burst--;
                return 0;
            end
            if ($urandom_range(0, 49) == 0)
                burst = $urandom_range(30, 150);
            r = $urandom_range(0, 99);
            if (r < 60)
                return 0;
            else if (r < 85)
                return $urandom_range(1, 3);
            else if (r < 97)
                return $urandom_range(4, 12);
            else
                return $urandom_range(20, 60);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        begin
            if (errors < MAX_PRINTS)
                $display("mismatch in %s at write %0d: expected %h, got %h",
                         what, writes_out, want, got);
            errors++;
        end
    endtask

    // source side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'h00;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                parse_byte(s_tdata);
                bytes_in++;
                quiet = 0;
            end
            else
                quiet++;
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (byte_stream.size() == 0)
                    s_tvalid <= 1'b0;
                else if (byte_stream[0].hold && !(pending_writes.size() == 0 && quiet >= 8))
                    s_tvalid <= 1'b0;
                else
                begin
                    head_byte = byte_stream.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= head_byte.data;
                    src_gap = pick_gap(src_burst);
                end
            end
        end
    end

    // sink side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_writes.size() == 0)
                    report_mismatch("unexpected beat", 32'd0, m_tdata);
                else
                begin
                    if (m_tdata[15:0] !== pending_writes[0].addr)
                        report_mismatch("write_address", 32'(pending_writes[0].addr),
                                        32'(m_tdata[15:0]));
                    if (m_tdata[31:16] !== pending_writes[0].data)
                        report_mismatch("write_data", 32'(pending_writes[0].data),
                                        32'(m_tdata[31:16]));
                    if (m_tuser !== pending_writes[0].kind)
                        report_mismatch("write_kind", 32'(pending_writes[0].kind),
                                        32'(m_tuser));
                    if (pending_writes[0].kind == oful_pkg::KIND_EMPTY)
                        empty_writes++;
                    void'(pending_writes.pop_front());
                end
                writes_out++;
            end
            if (snk_gap > 0)
            begin
                snk_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 4) == 0)
                    snk_gap = pick_gap(snk_burst);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("object_file_section_loader test failed");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        begin
            byte_stream.push_back('{b, pause_next});
            pause_next = 1'b0;
            total_pushed++;
        end
    endtask

    task automatic push_word(input logic [15:0] w);
        begin
            push_byte(w[15:8]);
            push_byte(w[7:0]);
        end
    endtask

    function automatic logic [15:0] pick_word();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                return 16'h0000;
            else if (r < 20)
                return 16'hFFFF;
            else
                return 16'($urandom);
        end
    endfunction

    function automatic int pick_count();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                return $urandom_range(0, 6);
            else if (r < 95)
                return $urandom_range(7, 20);
            else
                return $urandom_range(21, 60);
        end
    endfunction

    task automatic push_load_section(input logic [15:0] hdr, input logic [15:0] addr,
                                     input int n);
        begin
            push_word(hdr);
            push_word(addr);
            push_word(16'(n));
            for (int i = 0; i < n; i++)
                push_word(pick_word());
        end
    endtask

    task automatic push_skip_section(input logic [15:0] hdr, input int n);
        begin
            push_word(hdr);
            if (hdr == oful_pkg::HDR_SYMBOL)
                push_word(16'($urandom));
            if (hdr == oful_pkg::HDR_LINE)
                n = int'(oful_pkg::LINE_SKIP_BYTES);
            else
                push_word(16'(n));
            for (int i = 0; i < n; i++)
                push_byte(8'($urandom));
        end
    endtask

    initial
    begin
        logic [15:0] addr;
        int          r;
        int          next_pause;
        int          directed_len;

        for (int i = 0; i < 6; i++)
            sections_seen[i] = 0;

        // header found mid-stream after a partial match, address wraps at the top
        push_byte(8'h00);
        push_byte(8'hCA);
        push_word(oful_pkg::HDR_CODE);
        push_word(16'hFFFF);
        push_word(16'd3);
        push_word(16'h0000);
        push_word(16'hFFFF);
        push_word(16'h1234);
        // byte after a data section goes straight to the window
        push_word(oful_pkg::HDR_DATA);
        push_word(16'h0000);
        push_word(16'd1);
        push_word(16'h8001);
        push_load_section(oful_pkg::HDR_CODE, 16'h0010, 1);
        // zero count
        push_word(oful_pkg::HDR_DATA);
        push_word(16'h1234);
        push_word(16'd0);
        // symbol address ignored, line section, stale window must not match
        push_word(oful_pkg::HDR_SYMBOL);
        push_word(16'h5555);
        push_word(16'd1);
        push_byte(8'hCA);
        push_word(oful_pkg::HDR_LINE);
        for (int i = 0; i < 5; i++)
            push_byte(8'h00);
        push_byte(8'hCA);
        push_byte(8'hDE);
        push_word(oful_pkg::HDR_NAME);
        push_word(16'd0);
        push_load_section(oful_pkg::HDR_DATA, 16'h7FFF, 1);
        directed_len = total_pushed;

        next_pause = 0;
        while (total_pushed - directed_len < RANDOM_BYTES)
        begin
            if (total_pushed - directed_len >= next_pause)
            begin
                pause_next = 1'b1;
                next_pause += PAUSE_EVERY;
            end
            addr = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(16'hFFF0, 16'hFFFF))
                                               : 16'($urandom);
            r = $urandom_range(0, 99);
            if (r < 35)
                push_load_section(oful_pkg::HDR_CODE, addr, pick_count());
            else if (r < 65)
                push_load_section(oful_pkg::HDR_DATA, addr, pick_count());
            else if (r < 73)
                push_skip_section(oful_pkg::HDR_SYMBOL, pick_count());
            else if (r < 80)
                push_skip_section(oful_pkg::HDR_NAME, pick_count());
            else if (r < 86)
                push_skip_section(oful_pkg::HDR_LINE, 0);
            else if (r < 94)
            begin
                r = $urandom_range(1, 6);
                for (int i = 0; i < r; i++)
                    push_byte(8'($urandom));
            end
            else
            begin
                // header then a truncated body that runs on into later bytes
                case ($urandom_range(0, 4))
                    0: push_word(oful_pkg::HDR_CODE);
                    1: push_word(oful_pkg::HDR_DATA);
                    2: push_word(oful_pkg::HDR_SYMBOL);
                    3: push_word(oful_pkg::HDR_NAME);
                    default: push_word(oful_pkg::HDR_LINE);
                endcase
                r = $urandom_range(1, 5);
                for (int i = 0; i < r; i++)
                    push_byte(8'($urandom));
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_stream.size() != 0 || s_tvalid)
            @(posedge clk);
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("streamed %0d bytes, checked %0d writes (%0d empty)",
                 bytes_in, writes_out, empty_writes);
        $display("sections: code %0d, data %0d, symbol %0d, name %0d, line %0d",
                 sections_seen[int'(SEC_CODE)], sections_seen[int'(SEC_DATA)],
                 sections_seen[int'(SEC_SYMBOL)], sections_seen[int'(SEC_NAME)],
                 sections_seen[int'(SEC_LINE)]);
        if (errors == 0 && pending_writes.size() == 0)
            $display("object_file_section_loader test passed");
        else
            $display("object_file_section_loader test failed");
        $finish;
    end

endmodule
